[hw/rtl/sorm_pkg.sv]
// ----------------------------------------------------------------------------
// sorm_pkg
// Shared types and constants of the open-row SDRAM timing model.
// ----------------------------------------------------------------------------
package sorm_pkg;

  localparam int ADDR_BITS = 33;
  localparam int PAGE_BITS = 12;
  localparam int LAT_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;

  typedef enum logic [1:0] {
    KIND_READ     = 2'd0,
    KIND_WRITE    = 2'd1,
    KIND_PREFETCH = 2'd2,
    KIND_REFRESH  = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAS     = 3'd0,
    CFG_RCD     = 3'd1,
    CFG_RAS     = 3'd2,
    CFG_WR      = 3'd3,
    CFG_RP      = 3'd4,
    CFG_REFRESH = 3'd5,
    CFG_BEAT    = 3'd6,
    CFG_DRATE   = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [9:0]  cas_cycles;
    logic [9:0]  rcd_cycles;
    logic [9:0]  ras_cycles;
    logic [9:0]  wr_cycles;
    logic [9:0]  rp_cycles;
    logic [23:0] refresh_interval;
    logic [6:0]  cycles_per_bus_beat;
    logic        double_rate_shift;
  } cfg_t;

  // decoded item heading for the bank state stage
  typedef struct packed {
    logic  vld;
    kind_t kind;
    logic  empty;   // burst of zero chunks
  } item_ctl_t;

  // timed access heading for the result stage
  typedef struct packed {
    logic vld;
    logic row_hit;
  } res_ctl_t;

endpackage

[hw/rtl/sorm_decode.sv]
// ----------------------------------------------------------------------------
// sorm_decode
// Input register: splits the address into bank slot and row and works out
// the data transfer time of the burst.
// ----------------------------------------------------------------------------
module sorm_decode #(
  parameter int BANKS      = 8,
  parameter int BUS_BYTES  = 8,
  parameter int TIME_BITS  = 48,
  parameter int BANK_SEL_W = 3,
  parameter int RANK_SEL_W = 1,
  parameter int ROW_W      = 17,
  parameter int SLOT_W     = 4,
  parameter int DATA_W     = 17
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          acc,
  input  logic [1:0]                    in_kind,
  input  logic [32:0]                   in_address,
  input  logic [8:0]                    in_size_bytes,
  input  logic [47:0]                   in_now,
  input  sorm_pkg::cfg_t                cfg,
  output sorm_pkg::item_ctl_t           s1_ctl,
  output logic [SLOT_W-1:0]             s1_slot,
  output logic [ROW_W-1:0]              s1_row,
  output logic [DATA_W-1:0]             s1_data,
  output logic [TIME_BITS-1:0]          s1_now
);
  import sorm_pkg::*;

  localparam int BUS_SHIFT = $clog2(BUS_BYTES + 1) - 1;
  localparam int CHK_W     = $clog2(512 + BUS_BYTES);

  item_ctl_t             ctl_r, ctl_nxt;
  logic [SLOT_W-1:0]     slot_r, slot_nxt;
  logic [ROW_W-1:0]      row_r, row_nxt;
  logic [DATA_W-1:0]     data_r, data_nxt;
  logic [TIME_BITS-1:0]  now_r, now_nxt;

  logic [ADDR_BITS-1:0]  bank_f, row_f, rank_f;
  logic [CHK_W-1:0]      chunks;

  always_comb begin
    bank_f = (in_address >> PAGE_BITS) &
             ((ADDR_BITS'(1) << BANK_SEL_W) - ADDR_BITS'(1));
    row_f  = (in_address >> (PAGE_BITS + BANK_SEL_W)) &
             ((ADDR_BITS'(1) << ROW_W) - ADDR_BITS'(1));
    rank_f = in_address >> (PAGE_BITS + BANK_SEL_W + ROW_W);
    chunks = (CHK_W'(in_size_bytes) + CHK_W'(BUS_BYTES - 1)) >> BUS_SHIFT;

    ctl_nxt.vld   = acc;
    ctl_nxt.kind  = kind_t'(in_kind);
    ctl_nxt.empty = (chunks == '0);
    slot_nxt = SLOT_W'(rank_f) * SLOT_W'(BANKS) + SLOT_W'(bank_f);
    row_nxt  = ROW_W'(row_f);
    data_nxt = DATA_W'(chunks >> cfg.double_rate_shift) *
               DATA_W'(cfg.cycles_per_bus_beat);
    now_nxt  = TIME_BITS'(in_now);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    row_r  <= row_nxt;
    data_r <= data_nxt;
    now_r  <= now_nxt;
  end

  assign s1_ctl  = ctl_r;
  assign s1_slot = slot_r;
  assign s1_row  = row_r;
  assign s1_data = data_r;
  assign s1_now  = now_r;

endmodule

[hw/rtl/sorm_bank_state.sv]
// ----------------------------------------------------------------------------
// sorm_bank_state
// Per-bank open row and precharge time, bus free times and refresh walker.
// Times one item per cycle and updates the state in the same cycle.
// ----------------------------------------------------------------------------
module sorm_bank_state #(
  parameter int RANKS     = 2,
  parameter int BANKS     = 8,
  parameter int TIME_BITS = 48,
  parameter int ROW_W     = 17,
  parameter int SLOT_W    = 4,
  parameter int DATA_W    = 17
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sorm_pkg::cfg_t                cfg,
  input  sorm_pkg::item_ctl_t           s1_ctl,
  input  logic [SLOT_W-1:0]             s1_slot,
  input  logic [ROW_W-1:0]              s1_row,
  input  logic [DATA_W-1:0]             s1_data,
  input  logic [TIME_BITS-1:0]          s1_now,
  output sorm_pkg::res_ctl_t            s2_ctl,
  output logic [TIME_BITS-1:0]          s2_done,
  output logic [TIME_BITS-1:0]          s2_now
);
  import sorm_pkg::*;

  localparam int TW     = TIME_BITS;
  localparam int NSLOTS = RANKS * BANKS;
  localparam int RK_W   = (RANKS > 1) ? $clog2(RANKS) : 1;
  localparam int BK_W   = (BANKS > 1) ? $clog2(BANKS) : 1;

  function automatic logic [TW-1:0] tadd(input logic [TW-1:0] a,
                                         input logic [TW-1:0] b);
    logic [TW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TW] ? '1 : s[TW-1:0];
  endfunction

  function automatic logic [TW-1:0] tmax(input logic [TW-1:0] a,
                                         input logic [TW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  logic [ROW_W-1:0]    open_row_r [NSLOTS];
  logic [TW-1:0]       prt_r      [NSLOTS];

  logic [TW-1:0]       cbf_r, cbf_nxt;
  logic [TW-1:0]       dbf_r, dbf_nxt;
  logic [TW-1:0]       lrt_r, lrt_nxt;
  logic [RK_W-1:0]     rk_r, rk_nxt;
  logic [BK_W-1:0]     bk_r, bk_nxt;
  logic [ROW_W-1:0]    rw_r, rw_nxt;

  res_ctl_t            res_r, res_nxt;
  logic [TW-1:0]       done_r, done_nxt;
  logic [TW-1:0]       now2_r;

  logic                ent_we;
  logic [SLOT_W-1:0]   rd_slot;
  logic [ROW_W-1:0]    ent_row_nxt;
  logic [TW-1:0]       ent_prt_nxt;

  logic                is_ref, ref_due, hit, rk_last, bk_last;
  logic [SLOT_W-1:0]   ref_slot;
  logic [ROW_W-1:0]    row_sel, cur_row;
  logic [TW-1:0]       cur_prt, elapsed, data_t;
  logic [TW-1:0]       start0, lat_hit, lat_miss, wr_rp, ras_rp;
  logic [TW-1:0]       done_empty, hit_done, miss_start, miss_done;
  logic [TW-1:0]       ref_dn;

  always_comb begin
    is_ref   = s1_ctl.vld && (s1_ctl.kind == KIND_REFRESH);
    ref_slot = SLOT_W'(rk_r) * SLOT_W'(BANKS) + SLOT_W'(bk_r);
    rd_slot  = is_ref ? ref_slot : s1_slot;
    row_sel  = is_ref ? rw_r : s1_row;
    cur_row  = open_row_r[rd_slot];
    cur_prt  = prt_r[rd_slot];
    hit      = (cur_row == row_sel);

    // elapsed time wraps, so a clock going backwards still triggers
    elapsed  = s1_now - lrt_r;
    ref_due  = (cfg.refresh_interval != '0) &&
               (elapsed >= TW'(cfg.refresh_interval));

    data_t   = TW'(s1_data);
    wr_rp    = TW'(cfg.wr_cycles) + TW'(cfg.rp_cycles);
    ras_rp   = TW'(cfg.ras_cycles) + TW'(cfg.rp_cycles);
    lat_hit  = TW'(cfg.cas_cycles) + data_t;
    lat_miss = lat_hit + TW'(cfg.rcd_cycles);

    start0     = tmax(cbf_r, s1_now);
    done_empty = tadd(start0, TW'(cfg.rp_cycles) + TW'(cfg.ras_cycles) +
                              TW'(cfg.cas_cycles));
    hit_done   = tmax(tadd(start0, lat_hit), tadd(dbf_r, data_t));
    miss_start = tmax(tadd(start0, TW'(cfg.rp_cycles)), cur_prt);
    miss_done  = tadd(tmax(tadd(miss_start, lat_miss), dbf_r), data_t);
    ref_dn     = tadd(tmax(s1_now, cur_prt),
                      TW'(cfg.cas_cycles) + TW'(cfg.rcd_cycles));

    rk_last = (rk_r == RK_W'(RANKS - 1));
    bk_last = (bk_r == BK_W'(BANKS - 1));

    cbf_nxt     = cbf_r;
    dbf_nxt     = dbf_r;
    lrt_nxt     = lrt_r;
    rk_nxt      = rk_r;
    bk_nxt      = bk_r;
    rw_nxt      = rw_r;
    ent_we      = 1'b0;
    ent_row_nxt = row_sel;
    ent_prt_nxt = cur_prt;
    res_nxt     = '0;
    done_nxt    = done_empty;

    if (s1_ctl.vld) begin
      if (is_ref) begin
        if (ref_due) begin
          ent_we      = 1'b1;
          ent_prt_nxt = hit ? tadd(s1_now, wr_rp) : tadd(ref_dn, wr_rp);
          cbf_nxt     = tadd(cbf_r, TW'(cfg.cycles_per_bus_beat));
          lrt_nxt     = s1_now;
          // walk rank, then bank, then row
          rk_nxt      = rk_last ? '0 : rk_r + RK_W'(1);
          if (rk_last) begin
            bk_nxt = bk_last ? '0 : bk_r + BK_W'(1);
            if (bk_last) begin
              rw_nxt = rw_r + ROW_W'(1);
            end
          end
        end
      end else if (s1_ctl.empty) begin
        // zero-chunk burst: report only, no state change
        res_nxt.vld = 1'b1;
      end else begin
        res_nxt.vld     = 1'b1;
        res_nxt.row_hit = hit;
        if (hit) begin
          done_nxt = hit_done;
          if (s1_ctl.kind == KIND_WRITE) begin
            ent_we      = 1'b1;
            ent_prt_nxt = tadd(hit_done, wr_rp);
          end
        end else begin
          done_nxt    = miss_done;
          ent_we      = 1'b1;
          ent_prt_nxt = (s1_ctl.kind == KIND_WRITE) ? tadd(miss_done, wr_rp)
                                                    : tadd(miss_start, ras_rp);
        end
        dbf_nxt = done_nxt;
        cbf_nxt = tadd(cbf_r, TW'(cfg.cycles_per_bus_beat));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NSLOTS; i++) begin
        open_row_r[i] <= '0;
        prt_r[i]      <= '0;
      end
      cbf_r <= '0;
      dbf_r <= '0;
      lrt_r <= '0;
      rk_r  <= '0;
      bk_r  <= '0;
      rw_r  <= '0;
      res_r <= '0;
    end else begin
      if (ent_we) begin
        open_row_r[rd_slot] <= ent_row_nxt;
        prt_r[rd_slot]      <= ent_prt_nxt;
      end
      cbf_r <= cbf_nxt;
      dbf_r <= dbf_nxt;
      lrt_r <= lrt_nxt;
      rk_r  <= rk_nxt;
      bk_r  <= bk_nxt;
      rw_r  <= rw_nxt;
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    done_r <= done_nxt;
    now2_r <= s1_now;
  end

  assign s2_ctl  = res_r;
  assign s2_done = done_r;
  assign s2_now  = now2_r;

endmodule

[hw/rtl/sorm_result.sv]
// ----------------------------------------------------------------------------
// sorm_result
// Result register: latency from now to completion, saturated to 24 bits.
// ----------------------------------------------------------------------------
module sorm_result #(
  parameter int TIME_BITS = 48
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  sorm_pkg::res_ctl_t              s2_ctl,
  input  logic [TIME_BITS-1:0]            s2_done,
  input  logic [TIME_BITS-1:0]            s2_now,
  output logic                            out_strobe,
  output logic [sorm_pkg::LAT_W-1:0]      out_latency,
  output logic                            out_row_hit
);
  import sorm_pkg::*;

  logic                 strobe_r, strobe_nxt;
  logic [LAT_W-1:0]     lat_r, lat_nxt;
  logic                 hit_r, hit_nxt;
  logic [TIME_BITS-1:0] diff;

  always_comb begin
    diff       = (s2_done > s2_now) ? s2_done - s2_now : '0;
    lat_nxt    = ((diff >> LAT_W) != '0) ? '1 : LAT_W'(diff);
    strobe_nxt = s2_ctl.vld;
    hit_nxt    = s2_ctl.row_hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lat_r <= lat_nxt;
    hit_r <= hit_nxt;
  end

  assign out_strobe  = strobe_r;
  assign out_latency = lat_r;
  assign out_row_hit = hit_r;

endmodule

[hw/rtl/sdram_open_row_timing_model.sv]
// ----------------------------------------------------------------------------
// sdram_open_row_timing_model
// Open-page DRAM bank timing model: access latency and row-hit per item.
// ----------------------------------------------------------------------------
// Takes one item per clock; busy is always low. Each read, write or prefetch
// gives one result on out_strobe after the input register, bank state update
// and result register; a refresh check gives none. The per-bank state and bus
// times are read and written in the same cycle, so back-to-back items on one
// bank see each other's effects. The receiver cannot stall, so results must
// be taken as they appear. The user writes timing registers through cfg_we
// only while no item is in flight; the block itself does not enforce this.
module sdram_open_row_timing_model #(
  parameter int RANKS     = 2,
  parameter int BANKS     = 8,
  parameter int BUS_BYTES = 8,
  parameter int TIME_BITS = 48
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_kind,
  input  logic [32:0]                       in_address,
  input  logic [8:0]                        in_size_bytes,
  input  logic [47:0]                       in_now,
  input  logic                              cfg_we,
  input  logic [sorm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sorm_pkg::CFG_DAT_W-1:0]    cfg_data,
  output logic                              out_strobe,
  output logic [sorm_pkg::LAT_W-1:0]        out_latency,
  output logic                              out_row_hit
);
  import sorm_pkg::*;

  localparam int NSLOTS     = RANKS * BANKS;
  localparam int BANK_SEL_W = $clog2(BANKS + 1) - 1;
  localparam int RANK_SEL_W = $clog2(RANKS + 1) - 1;
  localparam int ROW_W      = ADDR_BITS - PAGE_BITS - BANK_SEL_W - RANK_SEL_W;
  localparam int SLOT_W     = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
  localparam int DATA_W     = $clog2(512 + BUS_BYTES) + 7;

  cfg_t                 cfg_r, cfg_nxt;
  logic                 acc;
  item_ctl_t            s1_ctl;
  logic [SLOT_W-1:0]    s1_slot;
  logic [ROW_W-1:0]     s1_row;
  logic [DATA_W-1:0]    s1_data;
  logic [TIME_BITS-1:0] s1_now;
  res_ctl_t             s2_ctl;
  logic [TIME_BITS-1:0] s2_done;
  logic [TIME_BITS-1:0] s2_now;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CAS:     cfg_nxt.cas_cycles          = cfg_data[9:0];
        CFG_RCD:     cfg_nxt.rcd_cycles          = cfg_data[9:0];
        CFG_RAS:     cfg_nxt.ras_cycles          = cfg_data[9:0];
        CFG_WR:      cfg_nxt.wr_cycles           = cfg_data[9:0];
        CFG_RP:      cfg_nxt.rp_cycles           = cfg_data[9:0];
        CFG_REFRESH: cfg_nxt.refresh_interval    = cfg_data[23:0];
        CFG_BEAT:    cfg_nxt.cycles_per_bus_beat = cfg_data[6:0];
        CFG_DRATE:   cfg_nxt.double_rate_shift   = cfg_data[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cas_cycles          <= 10'd60;
      cfg_r.rcd_cycles          <= 10'd60;
      cfg_r.ras_cycles          <= 10'd160;
      cfg_r.wr_cycles           <= 10'd60;
      cfg_r.rp_cycles           <= 10'd60;
      cfg_r.refresh_interval    <= 24'd0;
      cfg_r.cycles_per_bus_beat <= 7'd1;
      cfg_r.double_rate_shift   <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sorm_decode #(
    .BANKS      (BANKS),
    .BUS_BYTES  (BUS_BYTES),
    .TIME_BITS  (TIME_BITS),
    .BANK_SEL_W (BANK_SEL_W),
    .RANK_SEL_W (RANK_SEL_W),
    .ROW_W      (ROW_W),
    .SLOT_W     (SLOT_W),
    .DATA_W     (DATA_W)
  ) u_decode (
    .clk           (clk),
    .rst_n         (rst_n),
    .acc           (acc),
    .in_kind       (in_kind),
    .in_address    (in_address),
    .in_size_bytes (in_size_bytes),
    .in_now        (in_now),
    .cfg           (cfg_r),
    .s1_ctl        (s1_ctl),
    .s1_slot       (s1_slot),
    .s1_row        (s1_row),
    .s1_data       (s1_data),
    .s1_now        (s1_now)
  );

  sorm_bank_state #(
    .RANKS     (RANKS),
    .BANKS     (BANKS),
    .TIME_BITS (TIME_BITS),
    .ROW_W     (ROW_W),
    .SLOT_W    (SLOT_W),
    .DATA_W    (DATA_W)
  ) u_bank_state (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .s1_ctl  (s1_ctl),
    .s1_slot (s1_slot),
    .s1_row  (s1_row),
    .s1_data (s1_data),
    .s1_now  (s1_now),
    .s2_ctl  (s2_ctl),
    .s2_done (s2_done),
    .s2_now  (s2_now)
  );

  sorm_result #(
    .TIME_BITS (TIME_BITS)
  ) u_result (
    .clk         (clk),
    .rst_n       (rst_n),
    .s2_ctl      (s2_ctl),
    .s2_done     (s2_done),
    .s2_now      (s2_now),
    .out_strobe  (out_strobe),
    .out_latency (out_latency),
    .out_row_hit (out_row_hit)
  );

  // every access item yields exactly one result on out_strobe
  a_access_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_kind != KIND_REFRESH) |-> ##3 out_strobe)
    else $error("access item produced no result");

  a_result_has_access: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(acc && in_kind != KIND_REFRESH, 3))
    else $error("result without a matching access item");

  a_refresh_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_ctl.vld && s1_ctl.kind == KIND_REFRESH) |=> !s2_ctl.vld)
    else $error("refresh check produced a result");

endmodule
